FILE: design/asp_pkg.sv
// asp_pkg: shared constants, types and functions for the angular spectrum propagator
// used by the cell modules and the core; no dependencies
package asp_pkg;

  localparam int GRID_MAX     = 4096;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;
  localparam int SHIFT_W      = 5;

  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [2:0] REG_GRID_SIZE  = 3'd0;
  localparam logic [2:0] REG_WAVENUMBER = 3'd1;
  localparam logic [2:0] REG_PHASE      = 3'd2;
  localparam logic [2:0] REG_GAIN_A     = 3'd3;
  localparam logic [2:0] REG_GAIN_B     = 3'd4;

  typedef struct packed {
    logic               evan;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } side_t;

  // arctangent of 2^-idx in 2^-32 turns, built from the alternating series
  function automatic logic [31:0] atan_entry(input int idx);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] prod;
    int          e;
    sum = 64'd0;
    if (idx == 0) begin
      return 32'h2000_0000;
    end
    for (int n = 0; n < 32; n++) begin
      e = 62 - idx * (2 * n + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * n + 1);
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    prod = (sum >> 30) * INV_TWO_PI_Q32;
    return prod[63:32];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic same;
    same = (v[67:31] == '0) || (v[67:31] == '1);
    if (same) begin
      return v[31:0];
    end else if (v[67]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

FILE: design/asp_sqrt_cell.sv
// asp_sqrt_cell: one restoring square root step, two radicand bits per cell
// depends on asp_pkg
module asp_sqrt_cell import asp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] r_in,
  input  logic [31:0] q_in,
  input  logic [63:0] v_in,
  output logic [33:0] r_out,
  output logic [31:0] q_out,
  output logic [63:0] v_out
);

  logic [35:0] r_ext;
  logic [35:0] trial;
  logic [35:0] r_diff;
  logic        ge;

  assign r_ext  = {r_in, v_in[63:62]};
  assign trial  = {2'b00, q_in, 2'b01};
  assign ge     = (r_ext >= trial);
  assign r_diff = r_ext - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= ge ? r_diff[33:0] : r_ext[33:0];
      q_out <= {q_in[30:0], ge};
      v_out <= {v_in[61:0], 2'b00};
    end
  end

endmodule

FILE: design/asp_div_cell.sv
// asp_div_cell: one restoring division step, one quotient bit per cell
// depends on asp_pkg
module asp_div_cell import asp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic        dbit,
  input  logic [31:0] r_in,
  input  logic [31:0] q_in,
  input  logic [31:0] d_in,
  output logic [31:0] r_out,
  output logic [31:0] q_out,
  output logic [31:0] d_out
);

  logic [32:0] r_ext;
  logic [32:0] r_diff;
  logic        ge;

  assign r_ext  = {r_in, dbit};
  assign ge     = (r_ext >= {1'b0, d_in});
  assign r_diff = r_ext - {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= ge ? r_diff[31:0] : r_ext[31:0];
      q_out <= {q_in[30:0], ge};
      d_out <= d_in;
    end
  end

endmodule

FILE: design/asp_cordic_cell.sv
// asp_cordic_cell: one cordic rotation step on the x, y, z vector
// depends on asp_pkg
module asp_cordic_cell import asp_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SHIFT_W-1:0]  shift,
  input  logic [31:0]         atan,
  input  logic signed [33:0]  x_in,
  input  logic signed [33:0]  y_in,
  input  logic signed [33:0]  z_in,
  output logic signed [33:0]  x_out,
  output logic signed [33:0]  y_out,
  output logic signed [33:0]  z_out
);

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] da;

  assign dx = y_in >>> shift;
  assign dy = x_in >>> shift;
  assign da = $signed({2'b00, atan});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[33]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - da;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + da;
      end
    end
  end

endmodule

FILE: design/angular_spectrum_propagate_core.sv
// angular_spectrum_propagate_core: top level, k-grid cell in, propagated spectrum out
// depends on asp_pkg, asp_sqrt_cell, asp_div_cell, asp_cordic_cell
//
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    col_index, row_index, spec_a/b re/im
// output    out        out_valid / out_stall  field_re, field_im, evanescent
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one cell per cycle unless in_stall is raised; front end, sqrt, divide, phase, cordic and output stages
// the square root and divider cell rows resolve one bit pair or one bit per cell
// rst clears stage valid bits, output valid and the registers to their defaults
// out_stall with a full output register freezes every stage and raises in_stall
module angular_spectrum_propagate_core import asp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        col_index,
  input  logic [11:0]        row_index,
  input  logic signed [31:0] spec_a_re,
  input  logic signed [31:0] spec_a_im,
  input  logic signed [31:0] spec_b_re,
  input  logic signed [31:0] spec_b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] field_re,
  output logic signed [31:0] field_im,
  output logic               evanescent,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int LAT = 4 + SQRT_STEPS + DIV_STEPS + 2 + CORDIC_STEPS + 2;
  localparam int S4  = 3;

  logic [12:0] grid_size;
  logic [31:0] wavenumber;
  logic [47:0] phase_per_step;
  logic [31:0] gain_a;
  logic [31:0] gain_b;

  logic        adv;
  logic [LAT-1:0] vld_pipe;
  side_t       side_pipe [LAT];

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size      <= 13'd16;
      wavenumber     <= 32'd65536;
      phase_per_step <= 48'd0;
      gain_a         <= 32'd16777216;
      gain_b         <= 32'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_SIZE:  grid_size      <= cfg_data[12:0];
        REG_WAVENUMBER: wavenumber     <= cfg_data[31:0];
        REG_PHASE:      phase_per_step <= cfg_data;
        REG_GAIN_A:     gain_a         <= cfg_data[31:0];
        REG_GAIN_B:     gain_b         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front end: frequencies, squares, evanescence test
  logic [12:0]        grid_eff;
  logic [11:0]        centre;
  logic [63:0]        kp2;
  logic signed [12:0] k1, k2;
  logic [25:0]        k1sq, k2sq;
  logic [26:0]        kr;
  logic [63:0]        diff;
  logic signed [25:0] k1sq_full, k2sq_full;
  logic [63:0]        kr_sh;

  assign grid_eff  = (grid_size > 13'(GRID_MAX)) ? 13'(GRID_MAX) : grid_size;
  assign centre    = grid_eff[12:1];
  assign k1sq_full = k1 * k1;
  assign k2sq_full = k2 * k2;
  assign kr_sh     = {5'd0, kr, 32'd0};

  always_ff @(posedge clk) begin
    kp2 <= wavenumber * wavenumber;
    if (adv) begin
      k1   <= $signed({1'b0, col_index}) - $signed({1'b0, centre});
      k2   <= $signed({1'b0, row_index}) - $signed({1'b0, centre});
      k1sq <= k1sq_full;
      k2sq <= k2sq_full;
      kr   <= {1'b0, k1sq} + {1'b0, k2sq};
      diff <= kp2 - kr_sh;
    end
  end

  // stage valid bits and side payload
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (adv) begin
      vld_pipe <= {vld_pipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_pipe[0] <= '{evan: 1'b0, a_re: spec_a_re, a_im: spec_a_im,
                        b_re: spec_b_re, b_im: spec_b_im};
      for (int j = 1; j < LAT; j++) begin
        if (j == S4) begin
          side_pipe[j] <= '{evan: (kr_sh >= kp2), a_re: side_pipe[j-1].a_re,
                            a_im: side_pipe[j-1].a_im, b_re: side_pipe[j-1].b_re,
                            b_im: side_pipe[j-1].b_im};
        end else begin
          side_pipe[j] <= side_pipe[j-1];
        end
      end
    end
  end

  // square root row
  logic [33:0] sq_r [SQRT_STEPS+1];
  logic [31:0] sq_q [SQRT_STEPS+1];
  logic [63:0] sq_v [SQRT_STEPS+1];

  assign sq_r[0] = '0;
  assign sq_q[0] = '0;
  assign sq_v[0] = diff;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    asp_sqrt_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .r_in  (sq_r[i]),
      .q_in  (sq_q[i]),
      .v_in  (sq_v[i]),
      .r_out (sq_r[i+1]),
      .q_out (sq_q[i+1]),
      .v_out (sq_v[i+1])
    );
  end

  // divider row for (gain_a * 2^16) / kz
  logic [31:0] dv_r [DIV_STEPS+1];
  logic [31:0] dv_q [DIV_STEPS+1];
  logic [31:0] dv_d [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] ovf_pipe;

  assign dv_r[0] = {16'd0, gain_a[31:16]};
  assign dv_q[0] = '0;
  assign dv_d[0] = sq_q[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_pipe <= {ovf_pipe[DIV_STEPS-2:0], ({16'd0, gain_a[31:16]} >= sq_q[SQRT_STEPS])};
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic dbit;
    if (i < 16) begin : g_hi
      assign dbit = gain_a[15-i];
    end else begin : g_lo
      assign dbit = 1'b0;
    end
    asp_div_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .dbit  (dbit),
      .r_in  (dv_r[i]),
      .q_in  (dv_q[i]),
      .d_in  (dv_d[i]),
      .r_out (dv_r[i+1]),
      .q_out (dv_q[i+1]),
      .d_out (dv_d[i+1])
    );
  end

  // phase and coefficient
  logic [63:0]        ph_lo;
  logic [15:0]        ph_hi;
  logic [47:0]        ph_hi_full;
  logic [31:0]        ca_ph1, ca_ph2;
  logic [47:0]        ph_sum;
  logic [31:0]        angle;
  logic               fold;
  logic               flip_ph2;
  logic signed [33:0] z_start;

  assign ph_hi_full = phase_per_step[47:32] * dv_d[DIV_STEPS];
  assign ph_sum     = ph_lo[47:0] + {ph_hi, 32'd0};
  assign angle      = ph_sum[47:16];
  assign fold       = angle[31] ^ angle[30];

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_lo    <= phase_per_step[31:0] * dv_d[DIV_STEPS];
      ph_hi    <= ph_hi_full[15:0];
      ca_ph1   <= ovf_pipe[DIV_STEPS-1] ? 32'hffff_ffff : dv_q[DIV_STEPS];
      ca_ph2   <= ca_ph1;
      flip_ph2 <= fold;
      z_start  <= $signed({{2{angle[31] ^ fold}}, angle[31] ^ fold, angle[30:0]});
    end
  end

  // cordic row
  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [33:0] cz [CORDIC_STEPS+1];
  logic [CORDIC_STEPS-1:0] flip_pipe;
  logic [31:0]        ca_pipe [CORDIC_STEPS];

  assign cx[0] = CORDIC_GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z_start;

  always_ff @(posedge clk) begin
    if (adv) begin
      flip_pipe  <= {flip_pipe[CORDIC_STEPS-2:0], flip_ph2};
      ca_pipe[0] <= ca_ph2;
      for (int j = 1; j < CORDIC_STEPS; j++) begin
        ca_pipe[j] <= ca_pipe[j-1];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic [31:0] ATAN_I = atan_entry(i);
    asp_cordic_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .shift (SHIFT_W'(i)),
      .atan  (ATAN_I),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
  end

  // propagator components
  logic signed [33:0] cos_v, sin_v;
  logic signed [32:0] ka, kb;
  logic signed [66:0] pa_s, pa_c, pb_s, pb_c;
  logic signed [31:0] par, pai, pbr, pbi;

  assign cos_v = flip_pipe[CORDIC_STEPS-1] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign sin_v = flip_pipe[CORDIC_STEPS-1] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
  assign ka    = $signed({1'b0, ca_pipe[CORDIC_STEPS-1]});
  assign kb    = $signed({1'b0, gain_b});

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_s <= ka * sin_v;
      pa_c <= ka * cos_v;
      pb_s <= kb * sin_v;
      pb_c <= kb * cos_v;
      par  <= sat32((-(68'(pa_s))) >>> 30);
      pai  <= sat32(68'(pa_c) >>> 30);
      pbr  <= sat32((-(68'(pb_s))) >>> 30);
      pbi  <= sat32(68'(pb_c) >>> 30);
    end
  end

  // spectrum products
  side_t              sd;
  logic signed [63:0] m_ar_par, m_ai_pai, m_br_pbr, m_bi_pbi;
  logic signed [63:0] m_ar_pai, m_ai_par, m_br_pbi, m_bi_pbr;
  logic signed [39:0] ar_par, ai_pai, br_pbr, bi_pbi;
  logic signed [39:0] ar_pai, ai_par, br_pbi, bi_pbr;
  logic               vld_pm, evan_pm;

  assign sd       = side_pipe[LAT-1];
  assign m_ar_par = sd.a_re * par;
  assign m_ai_pai = sd.a_im * pai;
  assign m_br_pbr = sd.b_re * pbr;
  assign m_bi_pbi = sd.b_im * pbi;
  assign m_ar_pai = sd.a_re * pai;
  assign m_ai_par = sd.a_im * par;
  assign m_br_pbi = sd.b_re * pbi;
  assign m_bi_pbr = sd.b_im * pbr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pm <= 1'b0;
    end else if (adv) begin
      vld_pm <= vld_pipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      evan_pm <= sd.evan;
      ar_par  <= 40'(m_ar_par >>> 24);
      ai_pai  <= 40'(m_ai_pai >>> 24);
      br_pbr  <= 40'(m_br_pbr >>> 24);
      bi_pbi  <= 40'(m_bi_pbi >>> 24);
      ar_pai  <= 40'(m_ar_pai >>> 24);
      ai_par  <= 40'(m_ai_par >>> 24);
      br_pbi  <= 40'(m_br_pbi >>> 24);
      bi_pbr  <= 40'(m_bi_pbr >>> 24);
    end
  end

  // sums and output register
  logic signed [41:0] hr, hi;

  assign hr = 42'(ar_par) - 42'(ai_pai) + 42'(br_pbr) - 42'(bi_pbi);
  assign hi = 42'(ar_pai) + 42'(ai_par) + 42'(br_pbi) + 42'(bi_pbr);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_pm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      evanescent <= evan_pm;
      field_re   <= evan_pm ? 32'sd0 : sat32(68'(hr));
      field_im   <= evan_pm ? 32'sd0 : sat32(68'(hi));
    end
  end

`ifndef SYNTH
  a_evan_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && evanescent |-> field_re == 32'sd0 && field_im == 32'sd0)
    else $error("evanescent transaction with nonzero field");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld_pipe[0])
    else $error("accepted transaction missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld_pipe) && $stable(vld_pm))
    else $error("pipeline moved while stalled");
`endif

endmodule

FILE: bench/angular_spectrum_propagate_core_tb.sv
// angular_spectrum_propagate_core_tb: self-checking bench for the propagator core
// predicts each cell result from its own fixed-point model; depends on asp_pkg and the core
`timescale 1ns / 100ps

module angular_spectrum_propagate_core_tb;
  import asp_pkg::*;

  typedef struct {
    logic [11:0]        col;
    logic [11:0]        row;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cell_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               evan;
  } field_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] col_index = '0;
  logic [11:0] row_index = '0;
  logic signed [31:0] spec_a_re = '0, spec_a_im = '0, spec_b_re = '0, spec_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] field_re, field_im;
  logic evanescent;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  angular_spectrum_propagate_core dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow registers
  logic [12:0] m_grid;
  logic [31:0] m_kprime;
  logic [47:0] m_phase;
  logic [31:0] m_gain_a;
  logic [31:0] m_gain_b;
  logic [31:0] atan_tab [0:31];

  cell_t  pending_cells[$];
  field_t expected_fields[$];
  int errors = 0;
  int n_cells = 0;
  int n_evan = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit driving = 1'b0;

  function automatic logic [31:0] arctan_turns(input int idx);
    logic [63:0] acc, term, prod;
    int e;
    if (idx == 0) return 32'h2000_0000;
    acc = 0;
    for (int n = 0; n < 32; n++) begin
      e = 62 - idx * (2 * n + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * n + 1);
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
    end
    prod = (acc >> 30) * 64'd683565276;
    return prod[63:32];
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_tab[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_tab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic field_t propagate_cell(input cell_t t);
    field_t f;
    logic [12:0] n;
    longint ctr, k1, k2, c, s, k, par, pai, pbr, pbi, ar, ai, br, bi, hr, hi;
    logic [63:0] kr2, kp2, kz, ca, ph;
    n = (m_grid > GRID_MAX) ? 13'(GRID_MAX) : m_grid;
    ctr = longint'(n >> 1);
    k1 = longint'(t.col) - ctr;
    k2 = longint'(t.row) - ctr;
    kr2 = 64'(k1 * k1 + k2 * k2) << 32;
    kp2 = 64'(m_kprime) * 64'(m_kprime);
    if (kr2 >= kp2) begin
      f.re = 0; f.im = 0; f.evan = 1'b1;
      return f;
    end
    kz = floor_sqrt(kp2 - kr2);
    ph = (64'(m_phase) * kz) & 64'hFFFF_FFFF_FFFF;
    rotate(ph[47:16], c, s);
    ca = (64'(m_gain_a) << 16) / kz;
    if (ca > 64'hFFFF_FFFF) ca = 64'hFFFF_FFFF;
    k = longint'(ca);
    par = clamp32((-(k * s)) >>> 30);
    pai = clamp32((k * c) >>> 30);
    k = longint'(m_gain_b);
    pbr = clamp32((-(k * s)) >>> 30);
    pbi = clamp32((k * c) >>> 30);
    ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
    hr = ((ar * par) >>> 24) - ((ai * pai) >>> 24) + ((br * pbr) >>> 24) - ((bi * pbi) >>> 24);
    hi = ((ar * pai) >>> 24) + ((ai * par) >>> 24) + ((br * pbi) >>> 24) + ((bi * pbr) >>> 24);
    f.re = 32'(clamp32(hr));
    f.im = 32'(clamp32(hi));
    f.evan = 1'b0;
    return f;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s at result %0d: got %0d expected %0d", what, n_checked, got, want);
  endtask

  // driver: random gaps, payload held while stalled
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold
    end else begin
      if (in_valid) begin
        n_cells++;
        expected_fields.push_back(propagate_cell(pending_cells.pop_front()));
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (driving && pending_cells.size() > 0) begin
        in_valid  <= 1'b1;
        col_index <= pending_cells[0].col;
        row_index <= pending_cells[0].row;
        spec_a_re <= pending_cells[0].a_re;
        spec_a_im <= pending_cells[0].a_im;
        spec_b_re <= pending_cells[0].b_re;
        spec_b_im <= pending_cells[0].b_im;
        gap = ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result, then picks the next stall
  int stall_left = 0;
  bit calm;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_fields.size() == 0) begin
          errors++;
          $display("unexpected result %0d", n_checked);
        end else begin
          field_t e;
          e = expected_fields.pop_front();
          if (field_re != e.re) report_mismatch("field_re", field_re, e.re);
          if (field_im != e.im) report_mismatch("field_im", field_im, e.im);
          if (evanescent != e.evan) report_mismatch("evanescent", evanescent, e.evan);
          if (e.evan) n_evan++;
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_SIZE:  m_grid   = val[12:0];
      REG_WAVENUMBER: m_kprime = val[31:0];
      REG_PHASE:      m_phase  = val;
      REG_GAIN_A:     m_gain_a = val[31:0];
      REG_GAIN_B:     m_gain_b = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    driving = 1'b1;
    wait (pending_cells.size() == 0 && !in_valid);
    wait (expected_fields.size() == 0);
    driving = 1'b0;
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_spec();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cell(input logic [11:0] c, input logic [11:0] r,
                          input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
    cell_t t;
    t.col = c; t.row = r; t.a_re = ar; t.a_im = ai; t.b_re = br; t.b_im = bi;
    pending_cells.push_back(t);
  endtask

  // cells mostly near the centre so most are propagating
  task automatic add_random(input int count);
    int half, span;
    half = ((m_grid > GRID_MAX) ? GRID_MAX : m_grid) / 2;
    span = (m_kprime >> 16) + 2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0)
        add_cell($urandom, $urandom, rand_spec(), rand_spec(), rand_spec(), rand_spec());
      else
        add_cell(12'(half + $urandom_range(0, 2 * span) - span),
                 12'(half + $urandom_range(0, 2 * span) - span),
                 rand_spec(), rand_spec(), rand_spec(), rand_spec());
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) atan_tab[i] = arctan_turns(i);
    m_grid = 16; m_kprime = 32'h0001_0000; m_phase = 0;
    m_gain_a = 32'h0100_0000; m_gain_b = 32'h0100_0000;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, centre and corners, extreme spectra
    add_cell(8, 8, 32'h0100_0000, 0, 0, 0);
    add_cell(8, 8, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cell(9, 8, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    add_cell(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    add_cell(0, 0, 1, 1, 1, 1);
    drain();

    write_reg(REG_GRID_SIZE, 13);
    write_reg(REG_WAVENUMBER, 48'h0005_8000);
    write_reg(REG_PHASE, 48'h0000_4000_0000);
    write_reg(REG_GAIN_A, 48'hFFFF_FFFF);
    write_reg(REG_GAIN_B, 48'hFFFF_FFFF);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    add_cell(6, 6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cell(6, 6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cell(11, 6, 32'h0100_0000, 0, 32'h0100_0000, 0);
    add_cell(6, 1, 0, 32'h0100_0000, 0, 32'h0100_0000);
    add_cell(12, 6, 1, 2, 3, 4);
    drain();

    write_reg(REG_GRID_SIZE, 13'h1FFF);
    write_reg(REG_WAVENUMBER, 0);
    write_reg(REG_PHASE, 48'hFFFF_FFFF_FFFF);
    add_cell(2048, 2048, 32'h0100_0000, 0, 0, 0);
    add_cell(0, 12'hFFF, 32'h0100_0000, 0, 0, 0);
    drain();

    write_reg(REG_WAVENUMBER, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_A, 0);
    write_reg(REG_GAIN_B, 0);
    add_cell(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cell(2048, 2048, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cell(12'hFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();

    // backpressure: output held while input keeps offering
    write_reg(REG_GRID_SIZE, 64);
    write_reg(REG_WAVENUMBER, 32'h0010_0000);
    write_reg(REG_GAIN_A, 32'h0100_0000);
    write_reg(REG_GAIN_B, 32'h0080_0000);
    add_random(150);
    hold_off = 1'b1;
    driving = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // random phases across random settings
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_GRID_SIZE, $urandom_range(0, 1) ? 13'($urandom_range(16, 256) & ~1)
                                                    : 13'($urandom));
      write_reg(REG_WAVENUMBER, $urandom_range(0, 3) == 0 ? 48'($urandom)
                                : 48'($urandom_range(32'h0000_8000, 32'h0040_0000)));
      write_reg(REG_PHASE, {16'($urandom_range(0, 65535)), 32'($urandom)});
      write_reg(REG_GAIN_A, $urandom_range(0, 1) ? 48'($urandom) : 48'($urandom_range(0, 32'h0400_0000)));
      write_reg(REG_GAIN_B, $urandom_range(0, 1) ? 48'($urandom) : 48'($urandom_range(0, 32'h0400_0000)));
      calm = (p % 4 == 3);
      add_random(100);
      drain();
    end
    calm = 1'b0;

    $display("covered %0d cells, %0d evanescent, across grid, wavenumber, phase and gain settings",
             n_cells, n_evan);
    if (errors == 0 && expected_fields.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
